>>> sv/sljx_pkg.sv
// Package for the sync/length/XOR frame parser.
// Holds parse state codes, result kind codes, the result struct and frame limits.
// No dependencies.
package sljx_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 256;

    localparam logic [7:0] FIRST_SYNC_RESET  = 8'h4C;
    localparam logic [7:0] SECOND_SYNC_RESET = 8'h4D;

    localparam logic [1:0] ST_SYNC1 = 2'd0;
    localparam logic [1:0] ST_SYNC2 = 2'd1;
    localparam logic [1:0] ST_BODY  = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    localparam logic [1:0] KIND_SYNC   = 2'd0;
    localparam logic [1:0] KIND_BODY   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [0:0] REG_FIRST_SYNC  = 1'b0;
    localparam logic [0:0] REG_SECOND_SYNC = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] position;
        logic [7:0] frame_length;
    } t_result;

endpackage

>>> sv/sljx_parse.sv
// Per-byte parse state machine: sync hunt, length, body XOR and check byte.
// Depends on sljx_pkg.
module sljx_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_rx_byte,
    input  logic [7:0]           i_first_sync,
    input  logic [7:0]           i_second_sync,
    output sljx_pkg::t_result    o_result
);

    logic [1:0] r_state, n_state;
    logic [7:0] r_xor,   n_xor;
    logic [7:0] r_index, n_index;
    logic [7:0] r_len,   n_len;
    logic       idx_over;

    assign idx_over = {1'b0, r_index} >= 9'(sljx_pkg::MAX_FRAME_BYTES);

    always_comb begin
        n_state = r_state;
        n_xor   = r_xor;
        n_index = r_index;
        n_len   = r_len;
        o_result.kind      = sljx_pkg::KIND_SYNC;
        o_result.data_byte = 8'd0;
        o_result.position  = 8'd0;
        unique case (r_state)
            sljx_pkg::ST_SYNC1: begin
                if (i_rx_byte == i_first_sync) begin
                    n_state = sljx_pkg::ST_SYNC2;
                end else begin
                    o_result.kind = sljx_pkg::KIND_ERROR;
                end
            end
            sljx_pkg::ST_SYNC2: begin
                if (i_rx_byte == i_second_sync) begin
                    n_xor   = 8'd0;
                    n_index = 8'd0;
                    n_state = sljx_pkg::ST_BODY;
                end else begin
                    o_result.kind = sljx_pkg::KIND_ERROR;
                    n_state = sljx_pkg::ST_SYNC1;
                end
            end
            sljx_pkg::ST_BODY: begin
                if (idx_over) begin
                    o_result.kind = sljx_pkg::KIND_ERROR;
                    n_state = sljx_pkg::ST_SYNC1;
                end else begin
                    o_result.kind      = sljx_pkg::KIND_BODY;
                    o_result.data_byte = i_rx_byte;
                    o_result.position  = r_index;
                    if (r_index == 8'd0) begin
                        n_len = i_rx_byte;
                    end else begin
                        n_xor = r_xor ^ i_rx_byte;
                    end
                    n_index = r_index + 8'd1;
                    if (n_index == n_len) begin
                        n_state = sljx_pkg::ST_CHECK;
                    end
                end
            end
            default: begin
                o_result.kind = (i_rx_byte == r_xor) ? sljx_pkg::KIND_ACCEPT
                                                     : sljx_pkg::KIND_ERROR;
                n_state = sljx_pkg::ST_SYNC1;
            end
        endcase
        o_result.frame_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sljx_pkg::ST_SYNC1;
            r_xor   <= 8'd0;
            r_index <= 8'd0;
            r_len   <= 8'd0;
        end else if (i_take) begin
            r_state <= n_state;
            r_xor   <= n_xor;
            r_index <= n_index;
            r_len   <= n_len;
        end
    end

endmodule

>>> sv/sync_length_xor_frame_parser.sv
//  channel | direction | handshake                 | payload
//  rx      | in        | i_rx_valid / o_rx_stall   | i_rx_byte
//  res     | out       | o_res_valid / i_res_stall | o_kind, o_data_byte, o_position,
//          |           |                           | o_frame_length
//  cfg     | in        | APB write/read            | first/second sync byte
// One byte per cycle unless rx stalls; each byte yields one result in the next
// cycle from the result register. The rate is set by the single parse-state update.
// Synchronous active-low reset: hunting state, sync bytes 0x4C/0x4D, no result.
// A stalled result holds; rx stalls only while that result is held.
// Top level; depends on sljx_pkg and sljx_parse.
module sync_length_xor_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_position,
    output logic [7:0]  o_frame_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]         r_first_sync;
    logic [7:0]         r_second_sync;
    logic               r_res_valid;
    sljx_pkg::t_result  r_res;
    sljx_pkg::t_result  step_res;
    logic               take;
    logic               cfg_wr;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign o_rx_stall = r_res_valid && i_res_stall;
    assign take       = i_rx_valid && !o_rx_stall;

    always_comb begin
        unique case (paddr[2])
            sljx_pkg::REG_FIRST_SYNC: prdata = {24'd0, r_first_sync};
            default:                  prdata = {24'd0, r_second_sync};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= sljx_pkg::FIRST_SYNC_RESET;
            r_second_sync <= sljx_pkg::SECOND_SYNC_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == sljx_pkg::REG_FIRST_SYNC) begin
                r_first_sync <= pwdata[7:0];
            end else begin
                r_second_sync <= pwdata[7:0];
            end
        end
    end

    sljx_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_rx_byte     (i_rx_byte),
        .i_first_sync  (r_first_sync),
        .i_second_sync (r_second_sync),
        .o_result      (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_res_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= step_res;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_kind         = r_res.kind;
    assign o_data_byte    = r_res.data_byte;
    assign o_position     = r_res.position;
    assign o_frame_length = r_res.frame_length;

endmodule

>>> sv/sljx_checker.sv
// Port-level checker for the frame parser, bound to the top level.
// Depends on sljx_pkg and sync_length_xor_frame_parser.
module sljx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_rx_stall,
    input logic       o_res_valid,
    input logic       i_res_stall,
    input logic [1:0] o_kind,
    input logic [7:0] o_data_byte,
    input logic [7:0] o_position,
    input logic [7:0] o_frame_length
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |-> o_rx_stall)
        else $error("rx accepted while result held");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_stall) |=> (o_res_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_position) && $stable(o_frame_length)))
        else $error("stalled result changed");

    a_nonbody_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind != sljx_pkg::KIND_BODY)
            |-> (o_data_byte == 8'd0 && o_position == 8'd0))
        else $error("non-body result carries data");

    a_length_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == sljx_pkg::KIND_BODY && o_position == 8'd0)
            |-> (o_data_byte == o_frame_length))
        else $error("length byte not reported as frame length");

endmodule

bind sync_length_xor_frame_parser sljx_checker u_sljx_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_rx_stall     (o_rx_stall),
    .o_res_valid    (o_res_valid),
    .i_res_stall    (i_res_stall),
    .o_kind         (o_kind),
    .o_data_byte    (o_data_byte),
    .o_position     (o_position),
    .o_frame_length (o_frame_length)
);
